[hdl/ple_pkg.sv]
package ple_pkg;

	// Number of cells in the chain, and so the most entries the list holds.
	localparam int DEPTH = 16;
	// Width of the entry count, which must reach DEPTH itself.
	localparam int CNT_W = $clog2(DEPTH + 1);
	// Width used for cell indices and position arithmetic (covers 0..255).
	localparam int IX_W = 8;
	localparam int CMD_W = 3;
	localparam int ST_W = 3;
	localparam int LEN_W = 7;
	localparam int POS_W = 7;
	localparam int DATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND   = 3'd0,
		CMD_INSERT   = 3'd1,
		CMD_DEL_POS  = 3'd2,
		CMD_DEL_HEAD = 3'd3,
		CMD_DEL_TAIL = 3'd4,
		CMD_READ     = 3'd5
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 3'd0,
		ST_BADPOS = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_FULL   = 3'd3,
		ST_ENTRY  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CK_HOLD   = 2'd0,
		CK_INSERT = 2'd1,
		CK_REMOVE = 2'd2,
		CK_ROTATE = 2'd3
	} cell_kind_t;

	// Broadcast to every cell: what to do and over which index span.
	typedef struct packed {
		cell_kind_t      kind;
		logic [IX_W-1:0] lo;
		logic [IX_W-1:0] hi;
	} cell_ctl_t;

endpackage

[hdl/ple_cell.sv]
module ple_cell (
	input  logic                                  clk,
	input  logic [ple_pkg::IX_W-1:0]              idx,
	input  ple_pkg::cell_ctl_t                    ctl,
	input  logic signed [ple_pkg::DATA_W-1:0]     prev_data,
	input  logic signed [ple_pkg::DATA_W-1:0]     next_data,
	input  logic signed [ple_pkg::DATA_W-1:0]     load_data,
	output logic signed [ple_pkg::DATA_W-1:0]     data
);
	import ple_pkg::*;

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;

	// Each cell works out its own move from its index and the broadcast span.
	always_comb begin
		data_d = data_q;
		case (ctl.kind)
			CK_INSERT: begin
				if (idx == ctl.lo)
					data_d = load_data;
				else if (idx > ctl.lo && idx <= ctl.hi)
					data_d = prev_data;
			end
			CK_REMOVE: begin
				if (idx >= ctl.lo && idx < ctl.hi)
					data_d = next_data;
			end
			CK_ROTATE: begin
				if (idx >= ctl.lo && idx < ctl.hi)
					data_d = next_data;
				else if (idx == ctl.hi)
					data_d = load_data;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

[hdl/positional_list_engine.sv]
// Channel   Direction  Handshake                Word
// input     in         in_valid / in_ready      command, value, position
// output    out        out_valid / out_ready    status, entry_value, length, last
//
// An edit command's status word is placed in the output register as the
// command is accepted; edits can follow one another every cycle while the
// output is not stalled. After taking a read-out command, the input is held
// off while one word is sent per entry, as the cell chain rotates by one
// place per word so that cell 0 always holds the next entry. The next command
// can be taken once the final word has been placed in the output register.
// A stall on the output holds both the output register and the chain.
// Reset clears the entry count and the control state; cell contents are
// left as they are and are never read beyond the count.
module positional_list_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ple_pkg::CMD_W-1:0]             command,
	input  logic signed [ple_pkg::DATA_W-1:0]     value,
	input  logic [ple_pkg::POS_W-1:0]             position,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [ple_pkg::ST_W-1:0]              status,
	output logic signed [ple_pkg::DATA_W-1:0]     entry_value,
	output logic [ple_pkg::LEN_W-1:0]             length,
	output logic                                  last
);
	import ple_pkg::*;

	// Control state.
	logic             out_valid_q;
	logic             rd_active_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [CNT_W-1:0] count_q;

	// Output word register.
	logic [ST_W-1:0]          status_q;
	logic signed [DATA_W-1:0] entry_q;
	logic [LEN_W-1:0]         length_q;
	logic                     last_q;

	// Handshake.
	logic slot_free;
	logic in_fire;
	logic rd_step;

	// Command decode.
	logic [IX_W-1:0]  cnt_ix;
	logic [IX_W-1:0]  pos_ix;
	logic [IX_W-1:0]  pos_m1;
	logic [CNT_W-1:0] count_d;
	logic [ST_W-1:0]  edit_status;
	logic             start_read;
	logic             rd_last;
	cell_ctl_t        ctl;

	// Cell chain.
	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic signed [DATA_W-1:0] load_data;

	// The output register can take a new word when it is empty or being drained.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = !rd_active_q && slot_free;
	assign in_fire   = in_valid && in_ready;
	assign rd_step   = rd_active_q && slot_free;
	assign rd_last   = (rd_cnt_q + CNT_W'(1)) == count_q;

	assign cnt_ix = IX_W'(count_q);
	assign pos_ix = IX_W'(position);
	assign pos_m1 = pos_ix - IX_W'(1);

	// Decide the new count, the status and how the chain moves. During a
	// read-out the chain rotates one place towards the front, with the front
	// entry wrapping round into the last occupied cell.
	always_comb begin
		count_d     = count_q;
		edit_status = ST_OK;
		start_read  = 1'b0;
		ctl.kind    = CK_HOLD;
		ctl.lo      = '0;
		ctl.hi      = '0;
		load_data   = value;
		if (rd_step) begin
			ctl.kind  = CK_ROTATE;
			ctl.lo    = '0;
			ctl.hi    = cnt_ix - IX_W'(1);
			load_data = cell_data[0];
		end else if (in_fire) begin
			case (command)
				CMD_APPEND: begin
					if (count_q >= CNT_W'(DEPTH)) begin
						edit_status = ST_FULL;
					end else begin
						ctl.kind = CK_INSERT;
						ctl.lo   = cnt_ix;
						ctl.hi   = cnt_ix;
						count_d  = count_q + CNT_W'(1);
					end
				end
				CMD_INSERT: begin
					if (pos_ix == '0 || pos_ix > cnt_ix + IX_W'(1)) begin
						edit_status = ST_BADPOS;
					end else if (count_q >= CNT_W'(DEPTH)) begin
						edit_status = ST_FULL;
					end else begin
						ctl.kind = CK_INSERT;
						ctl.lo   = pos_m1;
						ctl.hi   = cnt_ix;
						count_d  = count_q + CNT_W'(1);
					end
				end
				CMD_DEL_POS: begin
					if (count_q == '0) begin
						edit_status = ST_EMPTY;
					end else if (pos_ix == '0 || pos_ix > cnt_ix) begin
						edit_status = ST_BADPOS;
					end else begin
						ctl.kind = CK_REMOVE;
						ctl.lo   = pos_m1;
						ctl.hi   = cnt_ix - IX_W'(1);
						count_d  = count_q - CNT_W'(1);
					end
				end
				CMD_DEL_HEAD: begin
					if (count_q == '0) begin
						edit_status = ST_EMPTY;
					end else begin
						ctl.kind = CK_REMOVE;
						ctl.lo   = '0;
						ctl.hi   = cnt_ix - IX_W'(1);
						count_d  = count_q - CNT_W'(1);
					end
				end
				CMD_DEL_TAIL: begin
					if (count_q == '0)
						edit_status = ST_EMPTY;
					else
						count_d = count_q - CNT_W'(1);
				end
				CMD_READ: begin
					if (count_q == '0)
						edit_status = ST_EMPTY;
					else
						start_read = 1'b1;
				end
				default: edit_status = ST_OK;
			endcase
		end
	end

	// The chain: each cell sees its neighbours on both sides; the ends see zero.
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic signed [DATA_W-1:0] prev_w;
			logic signed [DATA_W-1:0] next_w;
			if (gi == 0) begin : g_first
				assign prev_w = '0;
			end else begin : g_prev
				assign prev_w = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_end
				assign next_w = '0;
			end else begin : g_next
				assign next_w = cell_data[gi+1];
			end
			ple_cell u_cell (
				.clk       (clk),
				.idx       (IX_W'(gi)),
				.ctl       (ctl),
				.prev_data (prev_w),
				.next_data (next_w),
				.load_data (load_data),
				.data      (cell_data[gi])
			);
		end
	endgenerate

	// Control state. A read-out command loads no word of its own, so it
	// leaves the output register empty until the first entry word arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rd_active_q <= 1'b0;
			rd_cnt_q    <= '0;
			count_q     <= '0;
		end else begin
			if (slot_free)
				out_valid_q <= (in_fire && !start_read) || rd_step;
			count_q <= count_d;
			if (rd_step) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				if (rd_last)
					rd_active_q <= 1'b0;
			end else if (start_read) begin
				rd_cnt_q    <= '0;
				rd_active_q <= 1'b1;
			end
		end
	end

	// Output word. A read-out's entry words are loaded here once the read-out
	// is active, so the read-out command itself loads nothing here.
	always_ff @(posedge clk) begin
		if (rd_step) begin
			status_q <= ST_ENTRY;
			entry_q  <= cell_data[0];
			length_q <= LEN_W'(count_q);
			last_q   <= rd_last;
		end else if (in_fire && !start_read) begin
			status_q <= edit_status;
			entry_q  <= '0;
			length_q <= LEN_W'(count_d);
			last_q   <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_value = entry_q;
	assign length      = length_q;
	assign last        = last_q;

endmodule

[bench/positional_list_engine_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the list engine, keeps its own copy of the list
// and compares every output word with the oldest word still owed.
module positional_list_engine_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [ple_pkg::CMD_W-1:0]         command,
	input  logic signed [ple_pkg::DATA_W-1:0] value,
	input  logic [ple_pkg::POS_W-1:0]         position,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [ple_pkg::ST_W-1:0]          status,
	input  logic signed [ple_pkg::DATA_W-1:0] entry_value,
	input  logic [ple_pkg::LEN_W-1:0]         length,
	input  logic                              last,
	output int                                fail_count,
	output int                                pending_words,
	output int                                held_entries
);
	import ple_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic signed [DATA_W-1:0] entry_value;
		logic [LEN_W-1:0]         length;
		logic                     last;
	} list_word_t;

	logic signed [DATA_W-1:0] list_mem [DEPTH];
	int                       list_len;
	list_word_t               owed_words [$];
	int                       errors;

	task automatic owe_word(input status_t st, input logic signed [DATA_W-1:0] val,
			input logic fin);
		list_word_t w;
		w.status      = st;
		w.entry_value = val;
		w.length      = list_len[LEN_W-1:0];
		w.last        = fin;
		owed_words.push_back(w);
	endtask

	task automatic remove_entry(input int idx);
		int i;
		for (i = idx; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i + 1];
		list_len--;
	endtask

	// Applies one command to the local list and queues the words it answers with.
	task automatic apply_command(input logic [CMD_W-1:0] cmd,
			input logic signed [DATA_W-1:0] val, input logic [POS_W-1:0] pos);
		status_t st;
		int      p;
		int      i;
		st = ST_OK;
		p  = pos;
		case (cmd)
			CMD_APPEND: begin
				if (list_len >= DEPTH) begin
					st = ST_FULL;
				end else begin
					list_mem[list_len] = val;
					list_len++;
				end
			end
			CMD_INSERT: begin
				if (p < 1 || p > list_len + 1) begin
					st = ST_BADPOS;
				end else if (list_len >= DEPTH) begin
					st = ST_FULL;
				end else begin
					for (i = list_len; i > p - 1; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[p - 1] = val;
					list_len++;
				end
			end
			CMD_DEL_POS: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else if (p < 1 || p > list_len)
					st = ST_BADPOS;
				else
					remove_entry(p - 1);
			end
			CMD_DEL_HEAD: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else
					remove_entry(0);
			end
			CMD_DEL_TAIL: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else
					list_len--;
			end
			CMD_READ: begin
				if (list_len == 0) begin
					st = ST_EMPTY;
				end else begin
					for (i = 0; i < list_len; i++)
						owe_word(ST_ENTRY, list_mem[i], i + 1 == list_len);
					return;
				end
			end
			default: begin
			end
		endcase
		owe_word(st, '0, 1'b1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_words.delete();
			list_len      = 0;
			errors        = 0;
			fail_count    <= 0;
			pending_words <= 0;
			held_entries  <= 0;
		end else begin
			// The output is checked first: a word leaving now never belongs
			// to a command accepted at the same edge.
			if (out_valid && out_ready) begin
				if (owed_words.size() == 0) begin
					$error("unexpected word: status %0d, entry_value %0d, length %0d, last %0b",
						status, entry_value, length, last);
					errors++;
				end else begin
					list_word_t want;
					want = owed_words.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						errors++;
					end
					if (entry_value !== want.entry_value) begin
						$error("entry_value: expected %0d, actual %0d",
							want.entry_value, entry_value);
						errors++;
					end
					if (length !== want.length) begin
						$error("length: expected %0d, actual %0d", want.length, length);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, last);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				apply_command(command, value, position);
			fail_count    <= errors;
			pending_words <= owed_words.size();
			held_entries  <= list_len;
		end
	end

endmodule

[bench/positional_list_engine_tb.sv]
`timescale 1ns / 1ps

// Bench for the positional list engine. A short directed run walks through
// every command and each error case (empty list, full list, positions just
// outside the valid range), then a random run alternates between phases that
// tend to grow the list and phases that tend to shrink it, so that the list
// keeps passing through empty and full. The checker beside the block holds
// its own copy of the list; this module only makes stimulus and decides.
module positional_list_engine_tb;
	import ple_pkg::*;

	// The command field has two codes that the block treats as no-ops.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 30;
	localparam int PHASES      = 10;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;
	logic                     out_valid;
	logic                     out_ready;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] entry_value;
	logic [LEN_W-1:0]         length;
	logic                     last;

	int   fail_count;
	int   pending_words;
	int   held_entries;
	int   quiet_cycles;
	// When set, neither side idles: used for one long back-to-back stretch.
	logic steady;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	positional_list_engine u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.entry_value (entry_value),
		.length      (length),
		.last        (last)
	);

	positional_list_engine_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.value         (value),
		.position      (position),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.entry_value   (entry_value),
		.length        (length),
		.last          (last),
		.fail_count    (fail_count),
		.pending_words (pending_words),
		.held_entries  (held_entries)
	);

	// The receiver holds out_ready low about a fifth of the time, except in the steady stretch.
	always @(posedge clk)
		out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 20);

	// Watchdog: too long without any word moving on either channel means a hang.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Offers one command word and returns at the edge where it is taken. Valid
	// is left high so that a following word can go out back to back.
	task automatic send_word(input logic [CMD_W-1:0] cmd,
			input logic signed [DATA_W-1:0] val, input logic [POS_W-1:0] pos);
		while (!steady && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= val;
		position <= pos;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Holds the sender back until every owed word has come out. The first
	// edge lets the checker's counts take in the word accepted just now.
	task automatic drain_all();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Any position the field can carry.
	function automatic logic [POS_W-1:0] any_position();
		return POS_W'($urandom_range(0, 127));
	endfunction

	// Mostly positions inside the range that is valid for the current length
	// (top is the highest valid one), sometimes just outside it, sometimes anything.
	function automatic logic [POS_W-1:0] pick_position(input int top);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70 && top >= 1)
			return POS_W'($urandom_range(1, top));
		if (r < 85) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return top[POS_W-1:0];
				2: return top[POS_W-1:0] + POS_W'(1);
				default: return '1;
			endcase
		end
		return any_position();
	endfunction

	// One random command; a growing phase favours appends and inserts, a
	// shrinking phase favours the deletes.
	task automatic send_random(input logic growing);
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = held_entries;
		if (r >= 96)
			send_word($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO,
				$urandom, any_position());
		else if (growing ? r < 35 : r < 10)
			send_word(CMD_APPEND, pick_value(), any_position());
		else if (growing ? r < 60 : r < 20)
			send_word(CMD_INSERT, pick_value(), pick_position(n + 1));
		else if (growing ? r < 70 : r < 45)
			send_word(CMD_DEL_POS, $urandom, pick_position(n));
		else if (growing ? r < 77 : r < 60)
			send_word(CMD_DEL_HEAD, $urandom, any_position());
		else if (growing ? r < 84 : r < 75)
			send_word(CMD_DEL_TAIL, $urandom, any_position());
		else
			send_word(CMD_READ, $urandom, any_position());
	endtask

	initial begin
		int ph;
		int k;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = CMD_APPEND;
		value        = '0;
		position     = '0;
		out_ready    = 1'b0;
		steady       = 1'b0;
		quiet_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every command but append, asked of an empty list.
		send_word(CMD_READ, '0, '0);
		send_word(CMD_DEL_HEAD, '0, '0);
		send_word(CMD_DEL_TAIL, '0, '0);
		send_word(CMD_DEL_POS, '0, '0);
		send_word(CMD_DEL_POS, '0, '1);
		send_word(CMD_INSERT, 32'sd1, '0);
		send_word(CMD_INSERT, 32'sd2, 7'd2);
		// Build a short list with the extreme values, inserting at the front,
		// at one past the end and in the middle.
		send_word(CMD_INSERT, 32'sh8000_0000, 7'd1);
		send_word(CMD_APPEND, 32'sh7fff_ffff, '0);
		send_word(CMD_APPEND, '1, '1);
		send_word(CMD_INSERT, '0, 7'd4);
		send_word(CMD_INSERT, 32'sh5a5a_5a5a, 7'd2);
		// Positions just outside the valid range, and the far end of the field.
		send_word(CMD_INSERT, 32'sd3, '1);
		send_word(CMD_DEL_POS, '0, '0);
		send_word(CMD_DEL_POS, '0, 7'd6);
		send_word(CMD_SPARE_LO, '1, '0);
		send_word(CMD_SPARE_HI, 32'sh7fff_ffff, '1);
		send_word(CMD_READ, '0, '0);
		// Shrink back to nothing, taking the last entry off the end.
		send_word(CMD_DEL_POS, '0, 7'd3);
		send_word(CMD_DEL_HEAD, '0, '0);
		send_word(CMD_DEL_TAIL, '0, '0);
		send_word(CMD_DEL_TAIL, '0, '0);
		send_word(CMD_DEL_TAIL, '0, '0);
		drain_all();

		// Fill to the brim, then try every way of adding to a full list and
		// read the whole of it out.
		for (k = 0; k < DEPTH; k++)
			send_word(CMD_APPEND, $urandom, any_position());
		send_word(CMD_APPEND, '1, '0);
		send_word(CMD_INSERT, '1, 7'd1);
		send_word(CMD_INSERT, '1, 7'(DEPTH + 1));
		send_word(CMD_INSERT, '1, 7'(DEPTH + 2));
		send_word(CMD_READ, '0, '0);
		send_word(CMD_DEL_POS, '0, 7'(DEPTH));
		drain_all();

		// Random phases. The fourth runs back to back on both sides, and every
		// other phase ends with the sender waiting for the output to catch up.
		for (ph = 0; ph < PHASES; ph++) begin
			steady <= (ph == 3);
			for (k = 0; k < PHASE_ITEMS; k++)
				send_random(ph % 2 == 0);
			if (ph % 2 == 1)
				drain_all();
		end
		steady <= 1'b0;

		drain_all();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_words == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[positional_list_engine.f]
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine.sv
bench/positional_list_engine_checker.sv
bench/positional_list_engine_tb.sv
